// ----- hw/rtl/mxdp_pkg.sv -----
// ----------------------------------------------------------------------------
// mxdp_pkg
// Shared types, constants and decode tables for the MXFP4 block dot product.
// ----------------------------------------------------------------------------
package mxdp_pkg;

  localparam int FP_W    = 32;
  localparam int BF_W    = 16;
  localparam int MAG_W   = 51;   // exact magnitude width fed to the rounder
  localparam int EXP_W   = 11;   // signed exponent of the magnitude lsb
  localparam int ALIGN_W = 26;   // guard room above the smaller addend

  localparam logic [FP_W-1:0] FP_QNAN     = 32'h7FC0_0000;
  localparam logic [FP_W-1:0] FP_EXP_MASK = 32'h7F80_0000;
  localparam logic [FP_W-1:0] BF_RND_HALF = 32'h0000_7FFF;

  // lsb exponent of the smallest subnormal, and the fp32 significand lsb offset
  localparam logic signed [EXP_W-1:0] Q_MIN    = -11'sd149;
  localparam logic signed [EXP_W-1:0] SIG_OFS  = 11'sd150;
  localparam logic signed [EXP_W-1:0] PROD_OFS = 11'sd278;

  typedef enum logic [1:0] {
    K_NUM = 2'd0,
    K_INF = 2'd1,
    K_NAN = 2'd2
  } kind_t;

  // request into the shared round-and-pack unit: value = mag * 2^exp
  typedef struct packed {
    kind_t                   kind;
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic [MAG_W-1:0]        mag;
  } rnd_req_t;

  // doubled E2M1 magnitude: 0, 1, 2, 3, 4, 6, 8, 12
  function automatic logic [3:0] e2m1_twice(input logic [2:0] code);
    logic [3:0] m;
    unique case (code)
      3'd0: m = 4'd0;
      3'd1: m = 4'd1;
      3'd2: m = 4'd2;
      3'd3: m = 4'd3;
      3'd4: m = 4'd4;
      3'd5: m = 4'd6;
      3'd6: m = 4'd8;
      default: m = 4'd12;
    endcase
    return m;
  endfunction

  // floor(log2) of the doubled magnitude, for scale overflow detection
  function automatic logic [1:0] e2m1_flog(input logic [2:0] code);
    logic [1:0] f;
    unique case (code)
      3'd0, 3'd1: f = 2'd0;
      3'd2, 3'd3: f = 2'd1;
      3'd4, 3'd5: f = 2'd2;
      default:    f = 2'd3;
    endcase
    return f;
  endfunction

endpackage

// ----- hw/rtl/mxdp_in_if.sv -----
// ----------------------------------------------------------------------------
// mxdp_in_if
// Request channel: one packed weight byte, two activations, scale, last flag.
// ----------------------------------------------------------------------------
interface mxdp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  weight_pair;
  logic [31:0] act_even;
  logic [31:0] act_odd;
  logic [7:0]  group_scale;
  logic        last_item;

  modport source (output valid, weight_pair, act_even, act_odd, group_scale, last_item,
                  input ready);
  modport sink   (input valid, weight_pair, act_even, act_odd, group_scale, last_item,
                  output ready);
endinterface

// ----- hw/rtl/mxdp_out_if.sv -----
// ----------------------------------------------------------------------------
// mxdp_out_if
// Result channel: finished dot product as fp32 and bf16.
// ----------------------------------------------------------------------------
interface mxdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_fp32;
  logic [15:0] dot_bf16;

  modport source (output valid, dot_fp32, dot_bf16, input ready);
  modport sink   (input valid, dot_fp32, dot_bf16, output ready);
endinterface

// ----- hw/rtl/mxfp4_block_dot_product.sv -----
// ----------------------------------------------------------------------------
// mxfp4_block_dot_product
// MXFP4 weight byte times two fp32 activations, accumulated into an fp32 sum;
// the last request of a row emits the sum as fp32 and bf16 and clears it.
// ----------------------------------------------------------------------------
// Requests: taken only while idle, not before the last one is through. Each element
//   takes multiply, round, add and round, both rounds on one shared rounder.
// Result: registered out of the emit step that follows the last request,
//   which waits only while a previous result holds the output register.
// Reset: sequencer idle, running sum +0.0, no result pending.
// ----------------------------------------------------------------------------
module mxfp4_block_dot_product import mxdp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  mxdp_in_if.sink       in_ch,
  mxdp_out_if.source    out_ch
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_RNDP = 6'b000100,
    ST_ADD  = 6'b001000,
    ST_RNDS = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic              elem_r, elem_nxt;
  logic [7:0]        wp_r, gs_r;
  logic [FP_W-1:0]   ae_r, ao_r;
  logic              last_r;
  rnd_req_t          op_r, op_nxt;
  logic [FP_W-1:0]   p_r, sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [FP_W-1:0]   out_fp_r;
  logic [BF_W-1:0]   out_bf_r;
  logic [FP_W-1:0]   rnd_res;
  logic              in_fire, emit_go;

  // multiply-side signals
  logic [3:0]              code;
  logic [FP_W-1:0]         act;
  logic [3:0]              wm;
  logic [7:0]              ea_eff;
  logic [23:0]             a_sig;
  logic                    a_zero, a_inf, a_nan, w_zero, w_inf;
  logic [27:0]             prod;
  rnd_req_t                mul_req;

  // add-side signals
  logic                    s_nan, s_inf, p_nan, p_inf;
  logic [23:0]             s_sig, p_sig, a24, b24;
  logic signed [EXP_W-1:0] s_q, p_q, qa, qb, dq;
  logic                    sa, sb, s_big;
  logic [5:0]              dcl;
  logic [49:0]             a50, bj;
  logic [99:0]             bsh;
  rnd_req_t                add_req;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign emit_go     = (state_r == ST_EMIT) & (~out_valid_r | out_ch.ready);

  mxdp_round u_round (
    .req (op_r),
    .res (rnd_res)
  );

  // decode one element and form its exact product
  always_comb begin
    code   = elem_r ? wp_r[7:4] : wp_r[3:0];
    act    = elem_r ? ao_r : ae_r;
    wm     = e2m1_twice(code[2:0]);
    ea_eff = (act[30:23] == 8'd0) ? 8'd1 : act[30:23];
    a_sig  = {(act[30:23] != 8'd0), act[22:0]};
    a_zero = (act[30:0] == 31'd0);
    a_inf  = (act[30:23] == 8'hFF) & (act[22:0] == 23'd0);
    a_nan  = (act[30:23] == 8'hFF) & (act[22:0] != 23'd0);
    w_zero = (gs_r == 8'd0) | (wm == 4'd0);
    w_inf  = ~w_zero & (({1'b0, gs_r} + {7'd0, e2m1_flog(code[2:0])}) >= 9'd256);
    prod   = {24'd0, wm} * {4'd0, a_sig};
    mul_req.sign = code[3] ^ act[31];
    mul_req.exp  = $signed({3'd0, gs_r}) + $signed({3'd0, ea_eff}) - PROD_OFS;
    mul_req.mag  = w_zero ? '0 : MAG_W'(prod);
    priority if (a_nan | (a_inf & w_zero) | (w_inf & a_zero)) begin
      mul_req.kind = K_NAN;
    end else if (a_inf | w_inf) begin
      mul_req.kind = K_INF;
    end else begin
      mul_req.kind = K_NUM;
    end
  end

  // align and add the rounded product to the running sum
  always_comb begin
    s_nan = (sum_r[30:23] == 8'hFF) & (sum_r[22:0] != 23'd0);
    s_inf = (sum_r[30:23] == 8'hFF) & (sum_r[22:0] == 23'd0);
    p_nan = (p_r[30:23] == 8'hFF) & (p_r[22:0] != 23'd0);
    p_inf = (p_r[30:23] == 8'hFF) & (p_r[22:0] == 23'd0);
    s_sig = {(sum_r[30:23] != 8'd0), sum_r[22:0]};
    p_sig = {(p_r[30:23] != 8'd0), p_r[22:0]};
    s_q   = $signed({3'd0, (sum_r[30:23] == 8'd0) ? 8'd1 : sum_r[30:23]}) - SIG_OFS;
    p_q   = $signed({3'd0, (p_r[30:23] == 8'd0) ? 8'd1 : p_r[30:23]}) - SIG_OFS;
    s_big = (s_q >= p_q);
    a24   = s_big ? s_sig : p_sig;
    b24   = s_big ? p_sig : s_sig;
    sa    = s_big ? sum_r[31] : p_r[31];
    sb    = s_big ? p_r[31] : sum_r[31];
    qa    = s_big ? s_q : p_q;
    qb    = s_big ? p_q : s_q;
    dq    = qa - qb;
    dcl   = (dq > 11'sd63) ? 6'd63 : dq[5:0];
    a50   = {a24, 26'd0};
    bsh   = {b24, 26'd0, 50'd0} >> dcl;
    bj    = bsh[99:50] | {49'd0, |bsh[49:0]};
    add_req.exp = qa - 11'sd26;
    if (sa == sb) begin
      add_req.mag  = {1'b0, a50} + {1'b0, bj};
      add_req.sign = sa;
    end else if (a50 >= bj) begin
      add_req.mag  = {1'b0, a50 - bj};
      add_req.sign = sa;
    end else begin
      add_req.mag  = {1'b0, bj - a50};
      add_req.sign = sb;
    end
    // exact zero keeps the sign only when both addends are negative
    if (add_req.mag == '0) add_req.sign = sa & sb;
    priority if (s_nan | p_nan | (s_inf & p_inf & (sum_r[31] != p_r[31]))) begin
      add_req.kind = K_NAN;
    end else if (s_inf | p_inf) begin
      add_req.kind = K_INF;
      add_req.sign = s_inf ? sum_r[31] : p_r[31];
    end else begin
      add_req.kind = K_NUM;
    end
  end

  // sequence: multiply, round, add, round, per element; emit after a row's last request
  always_comb begin
    state_nxt     = state_r;
    elem_nxt      = elem_r;
    op_nxt        = op_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MUL;
          elem_nxt  = 1'b0;
        end
      end
      ST_MUL: begin
        op_nxt    = mul_req;
        state_nxt = ST_RNDP;
      end
      ST_RNDP: state_nxt = ST_ADD;
      ST_ADD: begin
        op_nxt    = add_req;
        state_nxt = ST_RNDS;
      end
      ST_RNDS: begin
        sum_nxt = rnd_res;
        if (!elem_r) begin
          elem_nxt  = 1'b1;
          state_nxt = ST_MUL;
        end else if (last_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          sum_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: latch the request, operands and the result
  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    op_r   <= op_nxt;
    if (state_r == ST_RNDP) p_r <= rnd_res;
    if (in_fire) begin
      wp_r   <= in_ch.weight_pair;
      ae_r   <= in_ch.act_even;
      ao_r   <= in_ch.act_odd;
      gs_r   <= in_ch.group_scale;
      last_r <= in_ch.last_item;
    end
    if (emit_go) begin
      out_fp_r <= sum_r;
      if ((sum_r & FP_EXP_MASK) == FP_EXP_MASK) begin
        out_bf_r <= sum_r[31:16];
      end else begin
        out_bf_r <= 16'((sum_r + BF_RND_HALF + {31'd0, sum_r[16]}) >> 16);
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.dot_fp32 = out_fp_r;
  assign out_ch.dot_bf16 = out_bf_r;

  // a new result appears only out of the emit step
  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit");

  // an emitted row leaves a cleared sum
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (sum_r == '0) && (state_r == ST_IDLE))
    else $error("sum not cleared after emit");

  // an accepted request starts on the even element
  a_start_even: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_MUL) && !elem_r)
    else $error("request did not start on the even element");

  // the running sum holds only the canonical NaN
  a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_r[30:23] == 8'hFF) && (sum_r[22:0] != 23'd0) |-> sum_r == FP_QNAN)
    else $error("non-canonical NaN in running sum");

endmodule

// ----- hw/rtl/mxdp_round.sv -----
// ----------------------------------------------------------------------------
// mxdp_round
// Shared round-and-pack unit: exact magnitude * 2^exp to fp32, nearest even,
// subnormals kept, overflow to infinity, NaN made canonical.
// ----------------------------------------------------------------------------
module mxdp_round import mxdp_pkg::*; (
  input  rnd_req_t          req,
  output logic [FP_W-1:0]   res
);

  logic [5:0]              lead;
  logic signed [EXP_W-1:0] top_e;
  logic signed [EXP_W-1:0] q;
  logic signed [EXP_W-1:0] r;
  logic signed [EXP_W-1:0] nr;
  logic [5:0]              rs;
  logic [MAG_W+51:0]       wide;
  logic [24:0]             mant;
  logic                    inc;
  logic [24:0]             mant_rnd;
  logic [8:0]              qb;
  logic [33:0]             total;

  always_comb begin
    // find the leading one
    lead = 6'd0;
    for (int i = 0; i < MAG_W; i++) begin
      if (req.mag[i]) lead = 6'(i);
    end
    top_e = req.exp + $signed({5'd0, lead});
    // pick the lsb exponent of the result: 24 bits or the subnormal floor
    q  = ((top_e - 11'sd23) < Q_MIN) ? Q_MIN : (top_e - 11'sd23);
    r  = q - req.exp;
    nr = -r;
    rs = (r > 11'sd63) ? 6'd63 : r[5:0];
    wide = {req.mag, 52'd0} >> rs;
    if (r < 11'sd0) begin
      mant = 25'(req.mag[23:0]) << nr[4:0];
      inc  = 1'b0;
    end else begin
      mant = wide[76:52];
      inc  = wide[51] & ((|wide[50:0]) | wide[52]);
    end
    mant_rnd = mant + 25'(inc);
    qb       = 9'(q - Q_MIN);
    total    = {2'd0, qb, 23'd0} + {9'd0, mant_rnd};

    // pack, with specials and zero first
    priority if (req.kind == K_NAN) begin
      res = FP_QNAN;
    end else if (req.kind == K_INF) begin
      res = {req.sign, FP_EXP_MASK[30:0]};
    end else if (req.mag == '0) begin
      res = {req.sign, 31'd0};
    end else if (total >= {2'd0, FP_EXP_MASK}) begin
      res = {req.sign, FP_EXP_MASK[30:0]};
    end else begin
      res = {req.sign, total[30:0]};
    end
  end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mxfp4_block_dot_product. A bit-exact fp32 predictor
// (round to nearest even, subnormals kept) accumulates each accepted request.
// Every row-final result is checked in order against the predicted fp32 and
// bf16 sums. Random gaps on both channels, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb import mxdp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  weight_pair;
    logic [31:0] act_even;
    logic [31:0] act_odd;
    logic [7:0]  group_scale;
    logic        last_item;
  } mac_req_t;

  typedef struct packed {
    logic [31:0] dot_fp32;
    logic [15:0] dot_bf16;
  } dot_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mxdp_in_if  in_ch();
  mxdp_out_if out_ch();

  mxfp4_block_dot_product dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink),
                               .out_ch(out_ch.source));

  always #2 clk = ~clk;

  mac_req_t    pending_reqs[$];
  dot_res_t    dot_expected[$];
  logic [31:0] row_sum = 32'h0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          quiet = 1'b0;
  int          reqs_accepted = 0;
  int          dots_checked = 0;
  int          special_dots = 0;
  int          errors = 0;
  int          idle_cycles = 0;

  // --------------------------------------------------------------------------
  // fp32 predictor
  // --------------------------------------------------------------------------
  // doubled E2M1 magnitudes
  const logic [3:0] twice_mag[8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd12};

  // round mag * 2^lsb_exp to fp32, nearest even
  function automatic logic [31:0] fp32_round(input logic sgn, input int lsb_exp,
                                             input logic [127:0] mag);
    int p, shift, lexp;
    logic [127:0] q, rem, half;
    if (mag == 0) return {sgn, 31'b0};
    p = 0;
    for (int i = 0; i < 128; i++) if (mag[i]) p = i;
    lexp = (lsb_exp + p >= -126) ? lsb_exp + p - 23 : -149;
    shift = lexp - lsb_exp;
    if (shift <= 0) begin
      q = mag << (-shift);
    end else if (shift >= 120) begin
      q = '0;
    end else begin
      q = mag >> shift;
      rem = mag & ((128'd1 << shift) - 1);
      half = 128'd1 << (shift - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
    end
    if (q[24]) begin
      q = q >> 1;
      lexp++;
    end
    if (q[23]) begin
      if (lexp + 150 >= 255) return {sgn, 8'hFF, 23'b0};
      return {sgn, 8'(lexp + 150), q[22:0]};
    end
    return {sgn, 8'h00, q[22:0]};
  endfunction

  function automatic bit is_nan(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic bit is_inf(input logic [31:0] x);
    return x[30:0] == 31'h7F80_0000;
  endfunction

  // significand and lsb exponent of a finite value
  function automatic void fp32_split(input logic [31:0] x, output logic [23:0] sig,
                                     output int lexp);
    if (x[30:23] == 0) begin
      sig = {1'b0, x[22:0]};
      lexp = -149;
    end else begin
      sig = {1'b1, x[22:0]};
      lexp = int'(x[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
    logic sgn;
    logic [23:0] sa, sb;
    int ea, eb;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return FP_QNAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return FP_QNAN;
      return {sgn, 31'h7F80_0000};
    end
    fp32_split(a, sa, ea);
    fp32_split(b, sb, eb);
    return fp32_round(sgn, ea + eb, 128'(sa) * 128'(sb));
  endfunction

  function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    logic [23:0] sa, sb;
    int ea, eb, d;
    logic [127:0] ma, mb;
    if (is_nan(a) || is_nan(b)) return FP_QNAN;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? FP_QNAN : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
    if (a[30:0] == 0) return b;
    if (b[30:0] == 0) return a;
    fp32_split(a, sa, ea);
    fp32_split(b, sb, eb);
    if (ea < eb) begin
      t = a; a = b; b = t;
      fp32_split(a, sa, ea);
      fp32_split(b, sb, eb);
    end
    d = ea - eb;
    mb = 128'(sb);
    // far below the larger operand: only a sticky bit survives
    if (d > 60) begin
      mb = 128'd1;
      eb = ea - 60;
      d = 60;
    end
    ma = 128'(sa) << d;
    if (a[31] == b[31]) return fp32_round(a[31], eb, ma + mb);
    if (ma == mb) return 32'h0;
    if (ma > mb) return fp32_round(a[31], eb, ma - mb);
    return fp32_round(b[31], eb, mb - ma);
  endfunction

  function automatic logic [31:0] mx_weight(input logic [3:0] code, input logic [7:0] scale);
    if (scale == 0 || code[2:0] == 0) return {code[3], 31'b0};
    return fp32_round(code[3], int'(scale) - 128, 128'(twice_mag[code[2:0]]));
  endfunction

  function automatic logic [15:0] bf16_of(input logic [31:0] x);
    logic [31:0] r;
    if ((x & FP_EXP_MASK) == FP_EXP_MASK) return x[31:16];
    r = x + BF_RND_HALF + {31'b0, x[16]};
    return r[31:16];
  endfunction

  // fold one accepted request into the running row sum
  function automatic void accumulate_pair(input mac_req_t r);
    logic [31:0] s;
    dot_res_t d;
    s = fp32_add(row_sum, fp32_mul(mx_weight(r.weight_pair[3:0], r.group_scale), r.act_even));
    s = fp32_add(s, fp32_mul(mx_weight(r.weight_pair[7:4], r.group_scale), r.act_odd));
    if (is_nan(s)) s = FP_QNAN;
    row_sum = s;
    if (r.last_item) begin
      d.dot_fp32 = s;
      d.dot_bf16 = bf16_of(s);
      dot_expected.insert(dot_expected.size(), d);
      row_sum = 32'h0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [31:0] rand_act();
    int r;
    logic [31:0] specials[8];
    specials = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                 32'h7F7F_FFFF, 32'h0000_0001, 32'hFFFF_FFFF};
    r = $urandom_range(99);
    if (r < 70) return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
    if (r < 80) return $urandom;
    if (r < 90) return specials[$urandom_range(7)];
    return {1'($urandom), 8'h00, 23'($urandom)};
  endfunction

  function automatic logic [7:0] rand_scale();
    int r;
    logic [7:0] ends[4];
    ends = '{8'd0, 8'd1, 8'd254, 8'd255};
    r = $urandom_range(99);
    if (r < 80) return 8'($urandom_range(110, 140));
    if (r < 90) return ends[$urandom_range(3)];
    return 8'($urandom);
  endfunction

  task automatic add_req(input logic [7:0] w, input logic [31:0] ae, input logic [31:0] ao,
                         input logic [7:0] s, input logic last);
    mac_req_t r;
    r = '{w, ae, ao, s, last};
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // --------------------------------------------------------------------------
  // driver: present the head of the pending queue, with random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accumulate_pair(pending_reqs.pop_front());
        reqs_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 || pending_reqs.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          in_ch.valid       <= 1'b1;
          in_ch.weight_pair <= pending_reqs[0].weight_pair;
          in_ch.act_even    <= pending_reqs[0].act_even;
          in_ch.act_odd     <= pending_reqs[0].act_odd;
          in_ch.group_scale <= pending_reqs[0].group_scale;
          in_ch.last_item   <= pending_reqs[0].last_item;
          // toggle between bursts with and without idling
          if ($urandom_range(49) == 0) quiet = ~quiet;
          gap_left <= quiet ? 0 : pick_gap();
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: check each result, stall at random, hold off once for long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        dots_checked++;
        if (dot_expected.size() == 0) begin
          $display("%0t: unexpected result fp32=%h bf16=%h", $time, out_ch.dot_fp32,
                   out_ch.dot_bf16);
          errors++;
        end else begin
          if (out_ch.dot_fp32 != dot_expected[0].dot_fp32) begin
            $display("%0t: dot_fp32 expected %h actual %h", $time,
                     dot_expected[0].dot_fp32, out_ch.dot_fp32);
            errors++;
          end
          if (out_ch.dot_bf16 != dot_expected[0].dot_bf16) begin
            $display("%0t: dot_bf16 expected %h actual %h", $time,
                     dot_expected[0].dot_bf16, out_ch.dot_bf16);
            errors++;
          end
          if (dot_expected[0].dot_fp32[30:23] == 8'hFF) special_dots++;
          void'(dot_expected.pop_front());
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && reqs_accepted >= 500) begin
        // long hold-off so the block backs up into its input
        out_ch.ready <= 1'b0;
        hold_done <= 1'b1;
        hold_left <= 400;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left <= quiet ? 0 : pick_gap();
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 3000) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int row_len;
    logic [7:0] scale;

    // zero code, all-negative codes, negative zero
    add_req(8'h00, 32'h3F80_0000, 32'h3F80_0000, 8'd127, 1'b1);
    add_req(8'hFF, 32'hBF80_0000, 32'hBF80_0000, 8'd127, 1'b1);
    add_req(8'h88, 32'h3F80_0000, 32'h3F80_0000, 8'd127, 1'b1);
    // zero scale times infinity gives NaN
    add_req(8'h77, 32'h7F80_0000, 32'h3F80_0000, 8'd0, 1'b1);
    // top scale codes 255 and 254: finite, overflow to inf, inf minus inf
    add_req(8'h11, 32'h3F80_0000, 32'h3F80_0000, 8'd255, 1'b1);
    add_req(8'h77, 32'h3F80_0000, 32'h3F80_0000, 8'd255, 1'b1);
    add_req(8'hF7, 32'h3F80_0000, 32'h3F80_0000, 8'd255, 1'b1);
    add_req(8'h17, 32'h3F80_0000, 32'hBF80_0000, 8'd254, 1'b1);
    // smallest scale code: subnormal weights and underflow
    add_req(8'h11, 32'h3F00_0000, 32'h3F00_0000, 8'd1, 1'b1);
    add_req(8'h21, 32'h0000_0001, 32'h8000_0001, 8'd1, 1'b1);
    // largest activation, subnormal activations, NaN activation
    add_req(8'h77, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 8'd128, 1'b1);
    add_req(8'h3B, 32'h807F_FFFF, 32'h007F_FFFF, 8'd140, 1'b1);
    add_req(8'h12, 32'h7FC0_0001, 32'h3F80_0000, 8'd127, 1'b1);
    // exact cancellation to zero
    add_req(8'h91, 32'h3F80_0000, 32'h3F80_0000, 8'd127, 1'b1);
    // bf16 ties and a carry through the mantissa
    add_req(8'h02, 32'h3F80_8000, 32'h0, 8'd127, 1'b1);
    add_req(8'h02, 32'h3F81_8000, 32'h0, 8'd127, 1'b1);
    add_req(8'h02, 32'hBF80_FFFF, 32'h0, 8'd127, 1'b1);
    // a multi-request row
    add_req(8'h35, 32'h4040_0000, 32'hC000_0000, 8'd126, 1'b0);
    add_req(8'hA6, 32'h3E80_0000, 32'h4100_0000, 8'd126, 1'b0);
    add_req(8'h4C, 32'h3FC0_0000, 32'hC0A0_0000, 8'd129, 1'b1);

    // random rows, one group scale per row with the odd change
    while (pending_reqs.size() < 1550) begin
      row_len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      scale = rand_scale();
      for (int i = 0; i < row_len; i++) begin
        if ($urandom_range(9) == 0) scale = rand_scale();
        add_req(8'($urandom), rand_act(), rand_act(), scale, i == row_len - 1);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || dot_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d requests and %0d row results (%0d inf/NaN), including a",
             reqs_accepted, dots_checked, special_dots);
    $display("long output hold-off with the input backed up.");
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
